/* design/rfp_pkg.sv */
// Shared types and constants for the rangefinder frame parser.
package rfp_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

    localparam logic [POS_W-1:0] POS_HEADER_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HEADER_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CODE          = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CHECKSUM      = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0] HEADER_FIRST  = 8'hB4;
    localparam logic [7:0] HEADER_SECOND = 8'h69;
    localparam int unsigned ERROR_BIT    = 7;

    // Field widths
    localparam int unsigned DIST_W  = 32;
    localparam int unsigned WHOLE_W = 26;
    localparam int unsigned HUND_W  = 7;

    // Divide by 100: q = (d * DIV100_MUL) >> DIV100_SHIFT, exact for any 32-bit d
    localparam logic [DIST_W-1:0] DIV100_MUL   = 32'h51EB_851F;
    localparam int unsigned       DIV100_SHIFT = 37;
    localparam logic [DIST_W-1:0] CM_DIVISOR   = 32'd100;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_HDR1_BAD   = 3'd1,
        STATUS_HDR2_BAD   = 3'd2,
        STATUS_CSUM_BAD   = 3'd3,
        STATUS_MODULE_ERR = 3'd4
    } status_t;

    // Verdict of one frame, with the held values it reports
    typedef struct packed {
        status_t           status;
        logic [7:0]        code;
        logic              module_error;
        logic [DIST_W-1:0] distance;
    } verdict_t;

endpackage

/* design/rfp_frame_check.sv */
// Byte framing, header and XOR checks, held result values and verdict register.
module rfp_frame_check
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [7:0]        rx_byte,
    output logic              verdict_valid,
    input  logic              verdict_ready,
    output rfp_pkg::verdict_t verdict
);

    logic [rfp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]                 xor_reg, xor_next;
    logic                       h1_bad_reg, h1_bad_next;
    logic                       h2_bad_reg, h2_bad_next;
    logic [7:0]                 code_reg, code_next;
    logic [rfp_pkg::DIST_W-1:0] shift_reg, shift_next;
    logic [rfp_pkg::DIST_W-1:0] held_distance_reg, held_distance_next;
    logic [7:0]                 held_code_reg, held_code_next;
    logic                       held_err_reg, held_err_next;
    logic                       v_valid_reg, v_valid_next;
    rfp_pkg::verdict_t          v_item_reg, v_item_next;
    rfp_pkg::status_t           status;
    logic                       accept;
    logic                       frame_end;

    // Take a byte whenever the verdict slot is free or drains this cycle
    assign byte_ready = !v_valid_reg || verdict_ready;
    assign accept     = byte_valid && byte_ready;
    assign frame_end  = accept && (pos_reg == rfp_pkg::POS_CHECKSUM);

    // Checks in priority order at the checksum byte
    always_comb
    begin
        if (h1_bad_reg)
            status = rfp_pkg::STATUS_HDR1_BAD;
        else if (h2_bad_reg)
            status = rfp_pkg::STATUS_HDR2_BAD;
        else if (xor_reg != rx_byte)
            status = rfp_pkg::STATUS_CSUM_BAD;
        else if (code_reg[rfp_pkg::ERROR_BIT])
            status = rfp_pkg::STATUS_MODULE_ERR;
        else
            status = rfp_pkg::STATUS_OK;
    end

    // Advance frame state on each accepted byte
    always_comb
    begin
        pos_next           = pos_reg;
        xor_next           = xor_reg;
        h1_bad_next        = h1_bad_reg;
        h2_bad_next        = h2_bad_reg;
        code_next          = code_reg;
        shift_next         = shift_reg;
        held_distance_next = held_distance_reg;
        held_code_next     = held_code_reg;
        held_err_next      = held_err_reg;
        if (accept)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == rfp_pkg::POS_HEADER_FIRST)
            begin
                xor_next    = rx_byte;
                h1_bad_next = (rx_byte != rfp_pkg::HEADER_FIRST);
            end
            else if (pos_reg == rfp_pkg::POS_CHECKSUM)
            begin
                if (status == rfp_pkg::STATUS_OK)
                begin
                    held_code_next     = code_reg;
                    held_err_next      = 1'b0;
                    held_distance_next = shift_reg;
                end
                else if (status == rfp_pkg::STATUS_MODULE_ERR)
                begin
                    held_code_next = code_reg;
                    held_err_next  = 1'b1;
                end
            end
            else
            begin
                xor_next = xor_reg ^ rx_byte;
                if (pos_reg == rfp_pkg::POS_HEADER_SECOND)
                    h2_bad_next = (rx_byte != rfp_pkg::HEADER_SECOND);
                else if (pos_reg == rfp_pkg::POS_CODE)
                    code_next = rx_byte;
                else
                    shift_next = {shift_reg[rfp_pkg::DIST_W-9:0], rx_byte};
            end
        end
    end

    // Load the verdict slot at frame end, empty it when taken
    always_comb
    begin
        v_valid_next = v_valid_reg;
        v_item_next  = v_item_reg;
        if (verdict_ready)
            v_valid_next = 1'b0;
        if (frame_end)
        begin
            v_valid_next              = 1'b1;
            v_item_next.status        = status;
            v_item_next.code          = held_code_next;
            v_item_next.module_error  = held_err_next;
            v_item_next.distance      = held_distance_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            xor_reg           <= '0;
            h1_bad_reg        <= 1'b0;
            h2_bad_reg        <= 1'b0;
            code_reg          <= '0;
            shift_reg         <= '0;
            held_distance_reg <= '0;
            held_code_reg     <= '0;
            held_err_reg      <= 1'b0;
            v_valid_reg       <= 1'b0;
        end
        else
        begin
            pos_reg           <= pos_next;
            xor_reg           <= xor_next;
            h1_bad_reg        <= h1_bad_next;
            h2_bad_reg        <= h2_bad_next;
            code_reg          <= code_next;
            shift_reg         <= shift_next;
            held_distance_reg <= held_distance_next;
            held_code_reg     <= held_code_next;
            held_err_reg      <= held_err_next;
            v_valid_reg       <= v_valid_next;
        end
    end

    // Verdict payload
    always_ff @(posedge clk)
    begin
        v_item_reg <= v_item_next;
    end

    assign verdict_valid = v_valid_reg;
    assign verdict       = v_item_reg;

`ifndef SYNTHESIS
    a_verdict_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v_valid_reg) |-> pos_reg == rfp_pkg::POS_HEADER_FIRST)
        else $error("verdict raised away from frame end");

    a_distance_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(held_distance_reg) |->
            v_valid_reg && v_item_reg.status == rfp_pkg::STATUS_OK)
        else $error("held distance changed without a good frame");
`endif

endmodule

/* design/rfp_cm_divider.sv */
// Two-stage divide by 100 of the held distance, ending in the result register.
module rfp_cm_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rfp_pkg::verdict_t           in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rfp_pkg::verdict_t           out_item,
    output logic [rfp_pkg::WHOLE_W-1:0] out_whole,
    output logic [rfp_pkg::HUND_W-1:0]  out_hundredths
);

    logic                          a_valid_reg;
    rfp_pkg::verdict_t             a_item_reg;
    logic [2*rfp_pkg::DIST_W-1:0]  a_prod_reg, a_prod_next;
    logic                          b_valid_reg;
    rfp_pkg::verdict_t             b_item_reg;
    logic [rfp_pkg::WHOLE_W-1:0]   b_whole_reg, b_whole_next;
    logic [rfp_pkg::HUND_W-1:0]    b_hund_reg, b_hund_next;
    logic [rfp_pkg::DIST_W-1:0]    rem_full;
    logic                          a_ready;
    logic                          b_ready;

    // Pipeline flow: a stage loads when its own slot is empty or is passed on downstream
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Stage A: reciprocal multiply
    assign a_prod_next = {{rfp_pkg::DIST_W{1'b0}}, in_item.distance}
                       * {{rfp_pkg::DIST_W{1'b0}}, rfp_pkg::DIV100_MUL};

    // Stage B: quotient from the product, remainder by back-multiply
    assign b_whole_next = a_prod_reg[rfp_pkg::DIV100_SHIFT+rfp_pkg::WHOLE_W-1:
                                     rfp_pkg::DIV100_SHIFT];
    assign rem_full     = a_item_reg.distance
                        - ({{(rfp_pkg::DIST_W-rfp_pkg::WHOLE_W){1'b0}}, b_whole_next}
                           * rfp_pkg::CM_DIVISOR);
    assign b_hund_next  = rem_full[rfp_pkg::HUND_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_item_reg <= in_item;
            a_prod_reg <= a_prod_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_item_reg  <= a_item_reg;
            b_whole_reg <= b_whole_next;
            b_hund_reg  <= b_hund_next;
        end
    end

    assign out_valid      = b_valid_reg;
    assign out_item       = b_item_reg;
    assign out_whole      = b_whole_reg;
    assign out_hundredths = b_hund_reg;

`ifndef SYNTHESIS
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> b_hund_reg < 7'd100)
        else $error("remainder out of range");

    a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |->
            ({{(rfp_pkg::DIST_W-rfp_pkg::WHOLE_W){1'b0}}, b_whole_reg} * rfp_pkg::CM_DIVISOR
             + {{(rfp_pkg::DIST_W-rfp_pkg::HUND_W){1'b0}}, b_hund_reg})
            == b_item_reg.distance)
        else $error("quotient and remainder do not rebuild the distance");

    a_stage_a_holds: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_ready |=> a_valid_reg && $stable(a_prod_reg))
        else $error("product lost while stalled");
`endif

endmodule

/* design/rangefinder_frame_parser_unit.sv */
// Top level of the rangefinder frame parser: stream ports and result packing.
//
// Channel  Dir  Bits  Contents
// s_*      in   8     rx_byte, one received serial byte
// m_*      out  80    frame_status, function_code, module_error, distance_raw,
//                     distance_cm_whole, distance_cm_hundredths (zero padded)
//
// One byte is taken each cycle while s_tready is high; every eighth byte yields one result.
// A result leaves the output register once its checksum byte is taken and it has passed the
// verdict register, multiply register, then quotient and remainder register.
// Reset clears the byte position, the frame checks and the held values to zero.
// A stall on m_tready fills the three result stages, then drops s_tready.
module rangefinder_frame_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata     // [2:0] frame_status, [10:3] function_code,
                                    // [11] module_error, [43:12] distance_raw,
                                    // [69:44] distance_cm_whole,
                                    // [76:70] distance_cm_hundredths, [79:77] zero
);

    logic                        v_valid;
    logic                        v_ready;
    rfp_pkg::verdict_t           v_item;
    rfp_pkg::verdict_t           r_item;
    logic [rfp_pkg::WHOLE_W-1:0] r_whole;
    logic [rfp_pkg::HUND_W-1:0]  r_hund;

    // Framing and checks
    rfp_frame_check u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (s_tvalid),
        .byte_ready    (s_tready),
        .rx_byte       (s_tdata),
        .verdict_valid (v_valid),
        .verdict_ready (v_ready),
        .verdict       (v_item)
    );

    // Centimeter split
    rfp_cm_divider u_div
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (v_valid),
        .in_ready       (v_ready),
        .in_item        (v_item),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_item       (r_item),
        .out_whole      (r_whole),
        .out_hundredths (r_hund)
    );

    // Pack result fields, lowest field first
    assign m_tdata = {3'b000, r_hund, r_whole, r_item.distance, r_item.module_error,
                      r_item.code, r_item.status};

endmodule

/* test/rangefinder_frame_parser_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking stream test of the rangefinder frame parser unit.
module rangefinder_frame_parser_unit_test;

    // One frame verdict as it appears on the result stream
    typedef struct packed {
        rfp_pkg::status_t             status;
        logic [7:0]                   code;
        logic                         module_error;
        logic [rfp_pkg::DIST_W-1:0]   distance;
        logic [rfp_pkg::WHOLE_W-1:0]  whole;
        logic [rfp_pkg::HUND_W-1:0]   hundredths;
    } frame_report_t;

    // Directed stimulus: one received byte, with a hand-written verdict where one is due
    typedef struct packed {
        logic [7:0]    rx;
        logic          has_want;
        frame_report_t want;
    } directed_row_t;

    typedef enum int {
        FRAME_GOOD,
        FRAME_HDR1_BAD,
        FRAME_HDR2_BAD,
        FRAME_CSUM_BAD
    } frame_kind_t;

    localparam int DIRECTED_ROWS = 32;
    localparam int RANDOM_BYTES  = 620;
    localparam int HOLD_OFF_LEN  = 80;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [rfp_pkg::DIST_W-1:0] DIST_MAX = '1;

    localparam frame_report_t NO_REPORT     = '0;
    localparam frame_report_t MAX_DIST_OK   =
        '{rfp_pkg::STATUS_OK, 8'h00, 1'b0, DIST_MAX, 26'd42949672, 7'd95};
    localparam frame_report_t ERR_FRAME     =
        '{rfp_pkg::STATUS_MODULE_ERR, 8'hFF, 1'b1, DIST_MAX, 26'd42949672, 7'd95};
    localparam frame_report_t HDR1_REJECTED =
        '{rfp_pkg::STATUS_HDR1_BAD, 8'hFF, 1'b1, DIST_MAX, 26'd42949672, 7'd95};
    localparam frame_report_t HDR2_REJECTED =
        '{rfp_pkg::STATUS_HDR2_BAD, 8'hFF, 1'b1, DIST_MAX, 26'd42949672, 7'd95};

    // Good frame at full distance, module error frame (distance held),
    // frame failing both headers and the checksum (first header wins), second header bad
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'hB4, 1'b0, NO_REPORT}, '{8'h69, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT}, '{8'hFF, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT}, '{8'hFF, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT}, '{8'hDD, 1'b1, MAX_DIST_OK},
        '{8'hB4, 1'b0, NO_REPORT}, '{8'h69, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT}, '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT}, '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT}, '{8'h22, 1'b1, ERR_FRAME},
        '{8'h00, 1'b0, NO_REPORT}, '{8'h00, 1'b0, NO_REPORT},
        '{8'h12, 1'b0, NO_REPORT}, '{8'h34, 1'b0, NO_REPORT},
        '{8'h56, 1'b0, NO_REPORT}, '{8'h78, 1'b0, NO_REPORT},
        '{8'h9A, 1'b0, NO_REPORT}, '{8'h00, 1'b1, HDR1_REJECTED},
        '{8'hB4, 1'b0, NO_REPORT}, '{8'h00, 1'b0, NO_REPORT},
        '{8'h01, 1'b0, NO_REPORT}, '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT}, '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT}, '{8'h00, 1'b1, HDR2_REJECTED}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;     // [2:0] frame_status, [10:3] function_code,
                              // [11] module_error, [43:12] distance_raw,
                              // [69:44] distance_cm_whole,
                              // [76:70] distance_cm_hundredths

    // Parser state as tracked by the test
    logic [rfp_pkg::POS_W-1:0]  frame_pos  = '0;
    logic [7:0]                 frame_xor  = '0;
    logic                       hdr1_bad   = 1'b0;
    logic                       hdr2_bad   = 1'b0;
    logic [7:0]                 code_byte  = '0;
    logic [rfp_pkg::DIST_W-1:0] dist_shift = '0;
    logic [rfp_pkg::DIST_W-1:0] held_dist  = '0;
    logic [7:0]                 held_code  = '0;
    logic                       held_err   = 1'b0;

    frame_report_t pending_reports [$];

    int send_idle_pct = 14;
    int recv_idle_pct = 45;
    int hold_off_left = 0;
    int bytes_sent    = 0;
    int stream_skew   = 0;
    int fail_count    = 0;

    rangefinder_frame_parser_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the frame tracker by one byte; report a verdict on every eighth
    task parse_rx_byte(input logic [7:0] rx, output logic done, output frame_report_t rep);
        logic [rfp_pkg::POS_W-1:0] pos;
        pos       = frame_pos;
        frame_pos = pos + 1'b1;
        done      = 1'b0;
        rep       = NO_REPORT;
        if (pos == rfp_pkg::POS_HEADER_FIRST)
        begin
            frame_xor = rx;
            hdr1_bad  = (rx != rfp_pkg::HEADER_FIRST);
        end
        else if (pos != rfp_pkg::POS_CHECKSUM)
        begin
            frame_xor = frame_xor ^ rx;
            if (pos == rfp_pkg::POS_HEADER_SECOND)
                hdr2_bad = (rx != rfp_pkg::HEADER_SECOND);
            else if (pos == rfp_pkg::POS_CODE)
                code_byte = rx;
            else
                dist_shift = {dist_shift[rfp_pkg::DIST_W-9:0], rx};
        end
        else
        begin
            done = 1'b1;
            // First failing check wins; rejected frames leave the held values alone
            if (hdr1_bad)
                rep.status = rfp_pkg::STATUS_HDR1_BAD;
            else if (hdr2_bad)
                rep.status = rfp_pkg::STATUS_HDR2_BAD;
            else if (frame_xor != rx)
                rep.status = rfp_pkg::STATUS_CSUM_BAD;
            else
            begin
                held_code = code_byte;
                if (code_byte[rfp_pkg::ERROR_BIT])
                begin
                    held_err   = 1'b1;
                    rep.status = rfp_pkg::STATUS_MODULE_ERR;
                end
                else
                begin
                    held_err   = 1'b0;
                    held_dist  = dist_shift;
                    rep.status = rfp_pkg::STATUS_OK;
                end
            end
            rep.code         = held_code;
            rep.module_error = held_err;
            rep.distance     = held_dist;
            rep.whole        = rfp_pkg::WHOLE_W'(held_dist / rfp_pkg::CM_DIVISOR);
            rep.hundredths   = rfp_pkg::HUND_W'(held_dist % rfp_pkg::CM_DIVISOR);
        end
    endtask

    // Offer one byte, idling at random first; track it once accepted
    task automatic send_rx_byte(input logic [7:0] rx, input logic has_want,
                                input frame_report_t want);
        logic          done;
        frame_report_t rep;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        parse_rx_byte(rx, done, rep);
        if (done)
            pending_reports.push_back(has_want ? want : rep);
        bytes_sent++;
    endtask

    // Build one frame with random content and the requested fault
    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]                 f [8];
        logic [7:0]                 code;
        logic [rfp_pkg::DIST_W-1:0] frame_dist;
        code = 8'($urandom_range(255));
        if ($urandom_range(3) != 0)
            code[rfp_pkg::ERROR_BIT] = 1'b0;
        case ($urandom_range(4))
            0:       frame_dist = 32'($urandom_range(999));
            1:       frame_dist = '0;
            2:       frame_dist = DIST_MAX;
            default: frame_dist = $urandom;
        endcase
        f[0] = rfp_pkg::HEADER_FIRST;
        f[1] = rfp_pkg::HEADER_SECOND;
        f[2] = code;
        {f[3], f[4], f[5], f[6]} = frame_dist;
        if (kind == FRAME_HDR1_BAD)
            f[0] = f[0] ^ 8'($urandom_range(1, 255));
        if (kind == FRAME_HDR2_BAD)
            f[1] = f[1] ^ 8'($urandom_range(1, 255));
        f[7] = f[0] ^ f[1] ^ f[2] ^ f[3] ^ f[4] ^ f[5] ^ f[6];
        if (kind == FRAME_CSUM_BAD)
            f[7] = f[7] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < 8; i++)
            send_rx_byte(f[i], 1'b0, NO_REPORT);
    endtask

    // Stray bytes shift the frame boundary; the parser never resynchronizes
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_rx_byte(8'($urandom_range(255)), 1'b0, NO_REPORT);
        stream_skew = (stream_skew + count) % 8;
    endtask

    // Main sequence: reset, directed table, random frames in three idle phases
    initial
    begin
        int pick;
        int phase;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        phase    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_rx_byte(DIRECTED[i].rx, DIRECTED[i].has_want, DIRECTED[i].want);

        while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES)
        begin
            // Swap idle rates, then run flat out behind a long output stall
            if (phase == 1 && bytes_sent >= DIRECTED_ROWS + 2 * RANDOM_BYTES / 3)
            begin
                phase         = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_off_left = HOLD_OFF_LEN;
            end
            else if (phase == 0 && bytes_sent >= DIRECTED_ROWS + RANDOM_BYTES / 3)
            begin
                phase         = 1;
                send_idle_pct = 45;
                recv_idle_pct = 14;
            end

            pick = $urandom_range(99);
            if (stream_skew != 0 && pick < 30)
                send_noise(8 - stream_skew);
            else if (pick < 6)
                send_noise($urandom_range(1, 7));
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_frame(FRAME_GOOD);
                else if (pick < 80)
                    send_frame(FRAME_HDR1_BAD);
                else if (pick < 90)
                    send_frame(FRAME_HDR2_BAD);
                else
                    send_frame(FRAME_CSUM_BAD);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("rangefinder_frame_parser_unit test passed");
        else
            $display("rangefinder_frame_parser_unit test failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                m_tready <= 1'b0;
                hold_off_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result item with the oldest pending verdict
    always @(posedge clk)
    begin
        frame_report_t got;
        frame_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status       = rfp_pkg::status_t'(m_tdata[2:0]);
            got.code         = m_tdata[10:3];
            got.module_error = m_tdata[11];
            got.distance     = m_tdata[43:12];
            got.whole        = m_tdata[69:44];
            got.hundredths   = m_tdata[76:70];
            if (pending_reports.size() == 0)
            begin
                $error("result item with no pending verdict: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.status != want.status)
                begin
                    $error("frame_status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.code != want.code)
                begin
                    $error("function_code: expected %h, got %h", want.code, got.code);
                    fail_count++;
                end
                if (got.module_error != want.module_error)
                begin
                    $error("module_error: expected %0d, got %0d",
                           want.module_error, got.module_error);
                    fail_count++;
                end
                if (got.distance != want.distance)
                begin
                    $error("distance_raw: expected %0d, got %0d", want.distance, got.distance);
                    fail_count++;
                end
                if (got.whole != want.whole)
                begin
                    $error("distance_cm_whole: expected %0d, got %0d", want.whole, got.whole);
                    fail_count++;
                end
                if (got.hundredths != want.hundredths)
                begin
                    $error("distance_cm_hundredths: expected %0d, got %0d",
                           want.hundredths, got.hundredths);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("rangefinder_frame_parser_unit test failed");
        $finish;
    end

endmodule
